// ===== src/fifo_cbk_pkg.sv =====
// Package for the keyed-cancel ticket FIFO: command and result transfer types,
// opcode and status codes, and default sizes. Used by fifo_with_cancel_by_key.
package fifo_cbk_pkg;

	localparam int DEPTH_DEF    = 32;
	localparam int KEY_BITS_DEF = 32;
	localparam int TKEY_BITS    = 32;
	localparam int WIDE_BITS    = 64;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_CANCEL = 2'd2,
		OP_LIST   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		opcode_t                opcode;
		logic [TKEY_BITS-1:0]   ticket_key;
	} cmd_t;

	typedef struct packed {
		status_t                status;
		logic [TKEY_BITS-1:0]   key_out;
		logic                   last_of_run;
		logic                   is_empty;
		logic                   is_full;
		logic [5:0]             entry_count;
	} rsp_t;

endpackage

// ===== src/fifo_with_cancel_by_key.sv =====
// Keyed-cancel ticket FIFO: a ring of DEPTH keys in one synchronous RAM; depends on fifo_cbk_pkg.
// Push, and any rejected or empty operation, show their result in the cycle after the
// transfer; pop passes through S_POP; cancel scans the N pending entries, then shifts.
// Throughput: busy stays high until the last result; list gives one result per cycle, N in all.
// The single RAM read port sets this sequence. With no receiver stall, done strobes per result.
// Reset (arst_n low, asynchronous) empties the queue; RAM contents stay undefined until written.
module fifo_with_cancel_by_key #(
	parameter int DEPTH    = fifo_cbk_pkg::DEPTH_DEF,
	parameter int KEY_BITS = fifo_cbk_pkg::KEY_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  fifo_cbk_pkg::cmd_t   cmd,
	output logic                 done,
	output fifo_cbk_pkg::rsp_t   result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Sequencer states. Every multi-cycle operation runs through the RAM read port.
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_POP   = 5'b00010,
		S_SCAN  = 5'b00100,
		S_SHIFT = 5'b01000,
		S_LIST  = 5'b10000
	} state_t;

	state_t                 state_q, state_d;
	logic [AW-1:0]          head_q, head_d;
	logic [CW-1:0]          occ_q, occ_d;
	logic [CW-1:0]          rd_pos_q, rd_pos_d;
	logic [CW-1:0]          dst_q, dst_d;
	logic [KEY_BITS-1:0]    key_q, key_d;
	logic [KEY_BITS-1:0]    rdata_q;
	logic [KEY_BITS-1:0]    mem [DEPTH];

	logic                   accept;
	logic [AW-1:0]          rd_addr;
	logic                   we;
	logic [AW-1:0]          waddr;
	logic [KEY_BITS-1:0]    wdata;
	logic [KEY_BITS-1:0]    key_in;
	logic [fifo_cbk_pkg::WIDE_BITS-1:0] key_wide;
	logic [fifo_cbk_pkg::WIDE_BITS-1:0] rdata_wide;

	logic                   done_d;
	fifo_cbk_pkg::status_t  res_status;
	logic [fifo_cbk_pkg::TKEY_BITS-1:0] res_key;
	logic                   res_last;
	logic                   done_q;
	fifo_cbk_pkg::rsp_t     result_q;

	// Ring slot of the entry at a given distance from the head.
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
	                                          input logic [CW-1:0] pos);
		logic [CW:0] sum;
		sum = (CW+1)'(head) + (CW+1)'(pos);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// Keys are cut to KEY_BITS on entry; listed and popped keys leave as their low 32 bits.
	assign key_wide   = fifo_cbk_pkg::WIDE_BITS'(cmd.ticket_key);
	assign key_in     = key_wide[KEY_BITS-1:0];
	assign rdata_wide = fifo_cbk_pkg::WIDE_BITS'(rdata_q);

	// The RAM is read every cycle. While idle it reads the head, which is what pop, cancel
	// and list all need first; otherwise it reads the position that the sequencer walks.
	assign rd_addr = (state_q == S_IDLE) ? head_q : slot_of(head_q, rd_pos_q);

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		occ_d      = occ_q;
		rd_pos_d   = rd_pos_q;
		dst_d      = dst_q;
		key_d      = key_q;
		we         = 1'b0;
		waddr      = slot_of(head_q, occ_q);
		wdata      = key_in;
		done_d     = 1'b0;
		res_status = fifo_cbk_pkg::ST_OK;
		res_key    = '0;
		res_last   = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd.opcode)
						fifo_cbk_pkg::OP_PUSH: begin
							done_d = 1'b1;
							if (occ_q == CW'(DEPTH)) begin
								res_status = fifo_cbk_pkg::ST_FULL;
							end else begin
								// The write lands at the tail slot at this very edge.
								we    = 1'b1;
								occ_d = occ_q + CW'(1);
							end
						end
						fifo_cbk_pkg::OP_POP,
						fifo_cbk_pkg::OP_CANCEL,
						fifo_cbk_pkg::OP_LIST: begin
							if (occ_q == '0) begin
								done_d     = 1'b1;
								res_status = fifo_cbk_pkg::ST_EMPTY;
							end else begin
								// The head read is issued now; position one is next.
								rd_pos_d = CW'(1);
								key_d    = key_in;
								priority case (cmd.opcode)
									fifo_cbk_pkg::OP_POP:    state_d = S_POP;
									fifo_cbk_pkg::OP_CANCEL: state_d = S_SCAN;
									default:                 state_d = S_LIST;
								endcase
							end
						end
					endcase
				end
			end
			S_POP: begin
				done_d  = 1'b1;
				res_key = rdata_wide[fifo_cbk_pkg::TKEY_BITS-1:0];
				head_d  = slot_of(head_q, CW'(1));
				occ_d   = occ_q - CW'(1);
				state_d = S_IDLE;
			end
			S_SCAN: begin
				// The read data holds the entry at position rd_pos_q - 1.
				if (rdata_q == key_q) begin
					if (rd_pos_q == occ_q) begin
						// The match is the newest entry, so nothing needs to move.
						done_d  = 1'b1;
						occ_d   = occ_q - CW'(1);
						state_d = S_IDLE;
					end else begin
						dst_d    = rd_pos_q - CW'(1);
						rd_pos_d = rd_pos_q + CW'(1);
						state_d  = S_SHIFT;
					end
				end else if (rd_pos_q == occ_q) begin
					done_d     = 1'b1;
					res_status = fifo_cbk_pkg::ST_NOTFOUND;
					state_d    = S_IDLE;
				end else begin
					rd_pos_d = rd_pos_q + CW'(1);
				end
			end
			S_SHIFT: begin
				// Each entry moves one place toward the head. The write trails the read
				// by two positions, so the two ports never meet at one entry.
				we    = 1'b1;
				waddr = slot_of(head_q, dst_q);
				wdata = rdata_q;
				dst_d = dst_q + CW'(1);
				if (rd_pos_q == occ_q) begin
					done_d  = 1'b1;
					occ_d   = occ_q - CW'(1);
					state_d = S_IDLE;
				end else begin
					rd_pos_d = rd_pos_q + CW'(1);
				end
			end
			S_LIST: begin
				done_d   = 1'b1;
				res_key  = rdata_wide[fifo_cbk_pkg::TKEY_BITS-1:0];
				res_last = (rd_pos_q == occ_q);
				if (rd_pos_q == occ_q) begin
					state_d = S_IDLE;
				end else begin
					rd_pos_d = rd_pos_q + CW'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Key RAM: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			occ_q    <= '0;
			rd_pos_q <= '0;
			dst_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			occ_q    <= occ_d;
			rd_pos_q <= rd_pos_d;
			dst_q    <= dst_d;
			done_q   <= done_d;
		end
	end

	// Result payload; the flags always describe the queue after the step.
	always_ff @(posedge clk) begin
		key_q                <= key_d;
		result_q.status      <= res_status;
		result_q.key_out     <= res_key;
		result_q.last_of_run <= res_last;
		result_q.is_empty    <= (occ_d == '0);
		result_q.is_full     <= (occ_d == CW'(DEPTH));
		result_q.entry_count <= 6'(occ_d);
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("occupancy exceeds depth");

	a_list_continues: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !result_q.last_of_run |=> done_q)
		else $error("list run broken before its last result");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && result_q.last_of_run |-> !busy)
		else $error("still busy after final result");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.opcode == fifo_cbk_pkg::OP_PUSH && occ_q != CW'(DEPTH)
		|=> occ_q == $past(occ_q) + CW'(1) && done_q)
		else $error("push did not add an entry");
`endif

endmodule

// ===== tb/sv/tb_fifo_with_cancel_by_key.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the keyed-cancel ticket FIFO, with directed and random commands.
// Depends on fifo_cbk_pkg and fifo_with_cancel_by_key.
module tb_fifo_with_cancel_by_key;

	localparam int DEPTH       = fifo_cbk_pkg::DEPTH_DEF;
	localparam int KEY_W       = fifo_cbk_pkg::TKEY_BITS;
	localparam int TOTAL_CMDS  = 100;     // random bursts may run past this total
	localparam int QUIET_TAIL  = 15;      // no idle gaps once this few commands remain
	localparam int PAUSE_A     = 10;      // commands that wait until every result is back
	localparam int PAUSE_B     = 70;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		fifo_cbk_pkg::cmd_t cmd;
		bit                 drain_first;
	} pend_cmd_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	fifo_cbk_pkg::cmd_t cmd;
	logic               done;
	fifo_cbk_pkg::rsp_t result;

	fifo_with_cancel_by_key #(
		.DEPTH   (DEPTH),
		.KEY_BITS(fifo_cbk_pkg::KEY_BITS_DEF)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.done  (done),
		.result(result)
	);

	// Commands waiting to be sent, and results the predictor says are still to come.
	pend_cmd_t            cmd_backlog[$];
	fifo_cbk_pkg::rsp_t   want_rsp[$];

	// Predictor state: a ring of keys, the slot of the oldest one and the fill level.
	logic [KEY_W-1:0]     key_ring[DEPTH];
	int                   ring_head;
	int                   ring_fill;

	// Shadow list of keys the stimulus generator uses to aim cancels at real entries.
	logic [KEY_W-1:0]     gen_keys[$];
	int                   gen_count;

	// Handshake between the rising-edge monitor and the falling-edge driver.
	bit                   took;
	bit                   presenting;
	int                   gap_left;

	int                   fault_cnt;
	int                   checked_cnt;
	int                   op_count[4];
	int                   status_count[4];
	int                   cycle_cnt;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Fill in the occupancy flags of a result from the predictor's state after the step.
	function automatic fifo_cbk_pkg::rsp_t stamp_occupancy(input fifo_cbk_pkg::rsp_t r);
		r.is_empty    = (ring_fill == 0);
		r.is_full     = (ring_fill >= DEPTH);
		r.entry_count = 6'(ring_fill);
		return r;
	endfunction

	// Apply one accepted command to the predicted queue and queue the results it causes.
	task automatic ticket_fifo_step(input fifo_cbk_pkg::cmd_t c);
		fifo_cbk_pkg::rsp_t r;
		int                 hit;
		r             = '0;
		r.last_of_run = 1'b1;
		case (c.opcode)
			fifo_cbk_pkg::OP_PUSH: begin
				if (ring_fill >= DEPTH) begin
					r.status = fifo_cbk_pkg::ST_FULL;
				end else begin
					key_ring[(ring_head + ring_fill) % DEPTH] = c.ticket_key;
					ring_fill++;
					r.status = fifo_cbk_pkg::ST_OK;
				end
				want_rsp.push_back(stamp_occupancy(r));
			end
			fifo_cbk_pkg::OP_POP: begin
				if (ring_fill == 0) begin
					r.status = fifo_cbk_pkg::ST_EMPTY;
				end else begin
					r.status  = fifo_cbk_pkg::ST_OK;
					r.key_out = key_ring[ring_head];
					ring_head = (ring_head + 1) % DEPTH;
					ring_fill--;
				end
				want_rsp.push_back(stamp_occupancy(r));
			end
			fifo_cbk_pkg::OP_CANCEL: begin
				hit = -1;
				for (int i = 0; i < ring_fill && hit < 0; i++)
					if (key_ring[(ring_head + i) % DEPTH] == c.ticket_key)
						hit = i;
				if (ring_fill == 0) begin
					r.status = fifo_cbk_pkg::ST_EMPTY;
				end else if (hit < 0) begin
					r.status = fifo_cbk_pkg::ST_NOTFOUND;
				end else begin
					// Close the gap so that the younger entries keep their order.
					for (int i = hit; i + 1 < ring_fill; i++)
						key_ring[(ring_head + i) % DEPTH] =
							key_ring[(ring_head + i + 1) % DEPTH];
					ring_fill--;
					r.status = fifo_cbk_pkg::ST_OK;
				end
				want_rsp.push_back(stamp_occupancy(r));
			end
			default: begin
				if (ring_fill == 0) begin
					r.status = fifo_cbk_pkg::ST_EMPTY;
					want_rsp.push_back(stamp_occupancy(r));
				end else begin
					for (int i = 0; i < ring_fill; i++) begin
						r.status      = fifo_cbk_pkg::ST_OK;
						r.key_out     = key_ring[(ring_head + i) % DEPTH];
						r.last_of_run = (i == ring_fill - 1);
						want_rsp.push_back(stamp_occupancy(r));
					end
				end
			end
		endcase
	endtask

	// Keys are drawn so that pushes repeat keys and cancels often hit a pending entry.
	function automatic logic [KEY_W-1:0] pick_key();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40 && gen_keys.size() > 0)
			return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
		if (roll < 60)
			return KEY_W'($urandom_range(0, 7));
		if (roll < 70)
			return ($urandom_range(0, 1) != 0) ? '1 : '0;
		return $urandom;
	endfunction

	// Append a command to the backlog and track what the queue will hold afterwards.
	task automatic queue_cmd(input fifo_cbk_pkg::opcode_t op, input logic [KEY_W-1:0] k);
		pend_cmd_t p;
		int        idx;
		p.cmd.opcode     = op;
		p.cmd.ticket_key = k;
		p.drain_first    = (gen_count == PAUSE_A) || (gen_count == PAUSE_B);
		cmd_backlog.push_back(p);
		gen_count++;
		case (op)
			fifo_cbk_pkg::OP_PUSH: begin
				if (gen_keys.size() < DEPTH)
					gen_keys.push_back(k);
			end
			fifo_cbk_pkg::OP_POP: begin
				if (gen_keys.size() > 0)
					void'(gen_keys.pop_front());
			end
			fifo_cbk_pkg::OP_CANCEL: begin
				idx = -1;
				for (int i = 0; i < gen_keys.size() && idx < 0; i++)
					if (gen_keys[i] == k)
						idx = i;
				if (idx >= 0)
					gen_keys.delete(idx);
			end
			default: ;
		endcase
	endtask

	// Driver: commands change on the falling edge. After each transfer an idle burst may
	// follow, except near the end of the run. A command marked to wait holds back until
	// every expected result has come out.
	always @(negedge clk) begin
		if (arst_n) begin
			if (took) begin
				took       = 1'b0;
				presenting = 1'b0;
				if (cmd_backlog.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
					gap_left = $urandom_range(1, 15);
			end
			if (!presenting) begin
				if (gap_left > 0)
					gap_left--;
				else if (cmd_backlog.size() > 0 &&
				         !(cmd_backlog[0].drain_first && want_rsp.size() > 0))
					presenting = 1'b1;
			end
			start <= presenting;
			if (presenting)
				cmd <= cmd_backlog[0].cmd;
		end
	end

	// Monitor: on each rising edge, check a result that is out, then take note of a
	// command transfer. A transfer at the same edge as the last result of the previous
	// command is predicted after that result has been checked.
	always @(posedge clk) begin : monitor
		fifo_cbk_pkg::rsp_t exp_rsp;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (want_rsp.size() == 0) begin
					if (fault_cnt < 10)
						$display("Unexpected result at cycle %0d: status %0d key %h last %0b",
						         cycle_cnt, result.status, result.key_out, result.last_of_run);
					fault_cnt++;
				end else begin
					exp_rsp = want_rsp.pop_front();
					checked_cnt++;
					status_count[exp_rsp.status]++;
					if (result.status !== exp_rsp.status ||
					    result.key_out !== exp_rsp.key_out ||
					    result.last_of_run !== exp_rsp.last_of_run ||
					    result.is_empty !== exp_rsp.is_empty ||
					    result.is_full !== exp_rsp.is_full ||
					    result.entry_count !== exp_rsp.entry_count) begin
						if (fault_cnt < 10) begin
							$display("Mismatch at cycle %0d:", cycle_cnt);
							$display("  expected status %0d key %h last %0b empty %0b full %0b count %0d",
							         exp_rsp.status, exp_rsp.key_out, exp_rsp.last_of_run,
							         exp_rsp.is_empty, exp_rsp.is_full, exp_rsp.entry_count);
							$display("  actual   status %0d key %h last %0b empty %0b full %0b count %0d",
							         result.status, result.key_out, result.last_of_run,
							         result.is_empty, result.is_full, result.entry_count);
						end
						fault_cnt++;
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				ticket_fifo_step(cmd);
				op_count[cmd.opcode]++;
				void'(cmd_backlog.pop_front());
				took = 1'b1;
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still expected",
			         cycle_cnt, want_rsp.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin : stimulus
		int roll;
		int burst;
		int mode;
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = '0;
		ring_head  = 0;
		ring_fill  = 0;
		gen_count  = 0;
		took       = 1'b0;
		presenting = 1'b0;
		gap_left   = 0;
		fault_cnt  = 0;
		checked_cnt = 0;
		cycle_cnt  = 0;
		foreach (op_count[i]) op_count[i] = 0;
		foreach (status_count[i]) status_count[i] = 0;

		// Directed part: every operation on an empty queue, extreme keys, duplicate keys
		// where only the oldest is cancelled, a cancel that misses, and popping to empty.
		queue_cmd(fifo_cbk_pkg::OP_LIST, 32'h0000_0000);
		queue_cmd(fifo_cbk_pkg::OP_POP, 32'hFFFF_FFFF);
		queue_cmd(fifo_cbk_pkg::OP_CANCEL, 32'hFFFF_FFFF);
		queue_cmd(fifo_cbk_pkg::OP_PUSH, 32'h0000_0000);
		queue_cmd(fifo_cbk_pkg::OP_PUSH, 32'hFFFF_FFFF);
		queue_cmd(fifo_cbk_pkg::OP_PUSH, 32'hA5A5_A5A5);
		queue_cmd(fifo_cbk_pkg::OP_PUSH, 32'hFFFF_FFFF);
		queue_cmd(fifo_cbk_pkg::OP_PUSH, 32'h5A5A_5A5A);
		queue_cmd(fifo_cbk_pkg::OP_LIST, 32'hFFFF_FFFF);
		queue_cmd(fifo_cbk_pkg::OP_CANCEL, 32'hFFFF_FFFF);
		queue_cmd(fifo_cbk_pkg::OP_LIST, 32'h1234_5678);
		queue_cmd(fifo_cbk_pkg::OP_CANCEL, 32'h1234_5678);
		queue_cmd(fifo_cbk_pkg::OP_CANCEL, 32'h0000_0000);
		queue_cmd(fifo_cbk_pkg::OP_CANCEL, 32'h5A5A_5A5A);
		queue_cmd(fifo_cbk_pkg::OP_POP, 32'h0000_0000);
		queue_cmd(fifo_cbk_pkg::OP_LIST, 32'h0000_0000);
		queue_cmd(fifo_cbk_pkg::OP_POP, 32'h0000_0000);
		queue_cmd(fifo_cbk_pkg::OP_POP, 32'h0000_0000);
		queue_cmd(fifo_cbk_pkg::OP_CANCEL, 32'h0000_0000);
		queue_cmd(fifo_cbk_pkg::OP_LIST, 32'h0000_0000);

		// Random part in bursts. The first burst fills the queue past full, then the
		// mix of bursts keeps it moving between empty, partly filled and full.
		mode = 3;
		while (gen_count < TOTAL_CMDS) begin
			case (mode)
				3: begin
					burst = DEPTH - gen_keys.size() + $urandom_range(1, 2);
					repeat (burst) queue_cmd(fifo_cbk_pkg::OP_PUSH, pick_key());
					queue_cmd(fifo_cbk_pkg::OP_LIST, $urandom);
				end
				4: begin
					burst = gen_keys.size() + 1;
					repeat (burst) queue_cmd(fifo_cbk_pkg::OP_POP, $urandom);
				end
				5: begin
					burst = $urandom_range(2, 6);
					repeat (burst) queue_cmd(fifo_cbk_pkg::OP_CANCEL, pick_key());
					queue_cmd(fifo_cbk_pkg::OP_LIST, $urandom);
				end
				default: begin
					burst = $urandom_range(3, 10);
					repeat (burst) begin
						roll = $urandom_range(0, 99);
						if (roll < 40)
							queue_cmd(fifo_cbk_pkg::OP_PUSH, pick_key());
						else if (roll < 60)
							queue_cmd(fifo_cbk_pkg::OP_POP, $urandom);
						else if (roll < 85)
							queue_cmd(fifo_cbk_pkg::OP_CANCEL, pick_key());
						else
							queue_cmd(fifo_cbk_pkg::OP_LIST, $urandom);
					end
				end
			endcase
			mode = $urandom_range(0, 5);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() > 0 || want_rsp.size() > 0)
			@(posedge clk);
		// A stray extra result would show up within the longest cancel time.
		repeat (2 * DEPTH + 8) @(posedge clk);

		$display("Sent %0d commands (push %0d, pop %0d, cancel %0d, list %0d), checked %0d results.",
		         op_count[fifo_cbk_pkg::OP_PUSH] + op_count[fifo_cbk_pkg::OP_POP] +
		         op_count[fifo_cbk_pkg::OP_CANCEL] + op_count[fifo_cbk_pkg::OP_LIST],
		         op_count[fifo_cbk_pkg::OP_PUSH], op_count[fifo_cbk_pkg::OP_POP],
		         op_count[fifo_cbk_pkg::OP_CANCEL], op_count[fifo_cbk_pkg::OP_LIST],
		         checked_cnt);
		$display("Statuses seen: ok %0d, full %0d, empty %0d, not found %0d; %0d faults.",
		         status_count[fifo_cbk_pkg::ST_OK], status_count[fifo_cbk_pkg::ST_FULL],
		         status_count[fifo_cbk_pkg::ST_EMPTY], status_count[fifo_cbk_pkg::ST_NOTFOUND],
		         fault_cnt);
		if (fault_cnt == 0 && want_rsp.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
